// ----- src/cursor_sprite_overlay_defines.svh -----
// ----------------------------------------------------------------------------
// Cursor sprite overlay assertion macros
// Shared assertion helpers, clocked on clk_i; CSO_ASSERT is held off while in reset.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SPRITE_OVERLAY_DEFINES_SVH
`define CURSOR_SPRITE_OVERLAY_DEFINES_SVH

// Property checked at every rising edge once reset is released.
`define CSO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every rising edge, also during reset.
`define CSO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/cso_pkg.sv -----
// ----------------------------------------------------------------------------
// Cursor sprite overlay package
// Register indexes, shape and hit codes, and the arrow bitmap.
// ----------------------------------------------------------------------------
package cso_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_X      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_Y      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_SHAPE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_COLOR  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIP_HEIGHT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CURSOR_ENABLE = 3'd5;

  localparam logic [7:0] CURSOR_COLOR_RESET = 8'd14;
  localparam logic [7:0] OUTLINE_COLOR      = 8'd0;

  // Offsets from the hotspot are kept in 12 signed bits.
  localparam int unsigned DELTA_W = 12;

  // Resize arrow geometry: shaft half length, diagonal half length, head size.
  localparam int ARM_LEN  = 7;
  localparam int DIAG_LEN = 6;
  localparam int HEAD_LEN = 3;

  localparam int unsigned ARROW_W = 12;
  localparam int unsigned ARROW_H = 16;

  typedef enum logic [2:0] {
    SHAPE_ARROW   = 3'd0,
    SHAPE_HORZ    = 3'd1,
    SHAPE_VERT    = 3'd2,
    SHAPE_DIAG_DR = 3'd3,
    SHAPE_DIAG_UR = 3'd4
  } shape_e;

  typedef enum logic [1:0] {
    KIND_MISS    = 2'd0,
    KIND_OUTLINE = 2'd1,
    KIND_FILL    = 2'd2
  } kind_e;

  // Arrow bitmap, one mask per row, bit n is column n.
  typedef logic [ARROW_W-1:0] arrow_row_t;

  localparam arrow_row_t ARROW_OUTLINE [ARROW_H] = '{
    12'h001, 12'h003, 12'h005, 12'h009, 12'h011, 12'h021, 12'h041, 12'h081,
    12'h101, 12'h021, 12'h029, 12'h045, 12'h043, 12'h081, 12'h080, 12'h180
  };

  localparam arrow_row_t ARROW_FILL [ARROW_H] = '{
    12'h000, 12'h000, 12'h002, 12'h006, 12'h00E, 12'h01E, 12'h03E, 12'h07E,
    12'h0FE, 12'h01E, 12'h016, 12'h022, 12'h020, 12'h040, 12'h040, 12'h000
  };

endpackage

// ----- src/cursor_sprite_overlay.sv -----
// ----------------------------------------------------------------------------
// Cursor sprite overlay
// Three-stage pipeline that draws a mouse cursor over a pixel stream.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream carries one pixel: its column, its row and
// the background palette index. The master stream returns one request per
// pixel, in order, with the composited palette index in tdata and a flag in
// tuser that is set when the cursor replaced the background.
// The cursor position, shape, color, clip height and enable are written on a
// plain register port; writes are meant to happen only while the pipeline is
// empty.
// A request accepted on the slave side passes through the three register
// stages in turn (offset subtraction, shape decode, color select) before its
// result shows on the master side. While the receiver is ready the pipeline
// takes one pixel every cycle, and each of the stages holds one pixel.
// When the receiver stalls, every stage holds its pixel and the slave side
// keeps accepting until all three stages are full, so nothing is lost or sent
// twice. Reset empties the pipeline and returns the registers to their reset
// values: cursor at the origin, arrow shape, color 14, full height, disabled.
// ----------------------------------------------------------------------------
`include "cursor_sprite_overlay_defines.svh"

module cursor_sprite_overlay
  import cso_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Pixel requests in.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [31:0]           s_axis_tdata_i,  // pixel_x[9:0], pixel_y[18:10],
                                                 // background[26:19], zero pad
  // Composited pixels out.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,  // pixel_out[7:0]
  output logic                  m_axis_tuser_o   // cursor_hit
);

  // Compare widths follow the screen size but never drop below the fields.
  localparam int XW = ($clog2(SCREEN_WIDTH + 1) > 10) ? $clog2(SCREEN_WIDTH + 1) : 10;
  localparam int YW = ($clog2(SCREEN_HEIGHT + 1) > 9) ? $clog2(SCREEN_HEIGHT + 1) : 9;

  localparam logic signed [DELTA_W-1:0] ARM_MIN  = DELTA_W'(-ARM_LEN);
  localparam logic signed [DELTA_W-1:0] ARM_MAX  = DELTA_W'(ARM_LEN);
  localparam logic signed [DELTA_W-1:0] DIAG_MIN = DELTA_W'(-DIAG_LEN);
  localparam logic signed [DELTA_W-1:0] DIAG_MAX = DELTA_W'(DIAG_LEN);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [10:0] cursor_x_q;
  logic signed [9:0]  cursor_y_q;
  shape_e             cursor_shape_q;
  logic [7:0]         cursor_color_q;
  logic [8:0]         clip_height_q;
  logic               cursor_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q      <= '0;
      cursor_y_q      <= '0;
      cursor_shape_q  <= SHAPE_ARROW;
      cursor_color_q  <= CURSOR_COLOR_RESET;
      clip_height_q   <= '0;
      cursor_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CURSOR_X:      cursor_x_q      <= $signed(cfg_wdata_i[10:0]);
        REG_CURSOR_Y:      cursor_y_q      <= $signed(cfg_wdata_i[9:0]);
        REG_CURSOR_SHAPE:  cursor_shape_q  <= shape_e'(cfg_wdata_i[2:0]);
        REG_CURSOR_COLOR:  cursor_color_q  <= cfg_wdata_i[7:0];
        REG_CLIP_HEIGHT:   clip_height_q   <= cfg_wdata_i[8:0];
        REG_CURSOR_ENABLE: cursor_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it moves on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: offsets from the hotspot and the visible-area test.
  // --------------------------------------------------------------------------
  logic [9:0]                 in_x;
  logic [8:0]                 in_y;
  logic [7:0]                 in_bg;
  logic [YW-1:0]              clip_ext;
  logic [YW-1:0]              row_limit;
  logic                       in_area_d;
  logic signed [DELTA_W-1:0]  dx_d, dy_d;

  logic signed [DELTA_W-1:0]  dx_q, dy_q;
  logic                       in_area_q;
  logic [7:0]                 bg1_q;

  assign in_x  = s_axis_tdata_i[9:0];
  assign in_y  = s_axis_tdata_i[18:10];
  assign in_bg = s_axis_tdata_i[26:19];

  always_comb begin
    clip_ext = YW'(clip_height_q);
    // A zero clip height, or one larger than the screen height, means the whole screen.
    if (clip_height_q == '0 || clip_ext > YW'(SCREEN_HEIGHT)) begin
      row_limit = YW'(SCREEN_HEIGHT);
    end else begin
      row_limit = clip_ext;
    end
    in_area_d = cursor_enable_q && (XW'(in_x) < XW'(SCREEN_WIDTH)) &&
                (YW'(in_y) < row_limit);
    dx_d = $signed({2'b00, in_x}) - $signed({cursor_x_q[10], cursor_x_q});
    dy_d = $signed({3'b000, in_y}) - $signed({{2{cursor_y_q[9]}}, cursor_y_q});
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      in_area_q <= in_area_d;
      bg1_q     <= in_bg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: shape decode.
  // --------------------------------------------------------------------------

  // Straight double-headed arrow along axis a; b is the cross offset.
  function automatic logic straight_hit(logic signed [DELTA_W-1:0] a,
                                        logic signed [DELTA_W-1:0] b);
    logic hit;
    hit = (b == '0) && (a >= ARM_MIN) && (a <= ARM_MAX);
    for (int i = -HEAD_LEN; i <= HEAD_LEN; i++) begin
      if ((a == DELTA_W'(-ARM_LEN + i) || a == DELTA_W'(ARM_LEN - i)) &&
          (b == DELTA_W'(i) || b == DELTA_W'(-i))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // Diagonal arrow from top-left to bottom-right, heads as corner brackets.
  function automatic logic diag_hit(logic signed [DELTA_W-1:0] a,
                                    logic signed [DELTA_W-1:0] b);
    logic hit;
    hit = (a == b) && (a >= DIAG_MIN) && (a <= DIAG_MAX);
    for (int i = 0; i <= HEAD_LEN; i++) begin
      if ((a == DELTA_W'(-DIAG_LEN + i) && b == DIAG_MIN) ||
          (a == DIAG_MIN && b == DELTA_W'(-DIAG_LEN + i)) ||
          (a == DELTA_W'(DIAG_LEN - i) && b == DIAG_MAX) ||
          (a == DIAG_MAX && b == DELTA_W'(DIAG_LEN - i))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  logic signed [DELTA_W-1:0] neg_dy;
  logic                      arrow_in;
  logic [3:0]                arrow_row;
  logic [3:0]                arrow_col;
  kind_e                     kind_d;
  kind_e                     kind_q;
  logic [7:0]                bg2_q;

  always_comb begin
    // The up-right diagonal is the down-right one mirrored vertically.
    neg_dy    = -dy_q;
    arrow_in  = (dx_q >= 0) && (dx_q < DELTA_W'(ARROW_W)) &&
                (dy_q >= 0) && (dy_q < DELTA_W'(ARROW_H));
    arrow_row = dy_q[3:0];
    arrow_col = dx_q[3:0];
    kind_d    = KIND_MISS;
    if (in_area_q) begin
      case (cursor_shape_q)
        SHAPE_HORZ:    if (straight_hit(dx_q, dy_q)) kind_d = KIND_FILL;
        SHAPE_VERT:    if (straight_hit(dy_q, dx_q)) kind_d = KIND_FILL;
        SHAPE_DIAG_DR: if (diag_hit(dx_q, dy_q)) kind_d = KIND_FILL;
        SHAPE_DIAG_UR: if (diag_hit(dx_q, neg_dy)) kind_d = KIND_FILL;
        default: begin
          // The unused codes draw the normal arrow as well.
          if (arrow_in) begin
            if (ARROW_FILL[arrow_row][arrow_col]) begin
              kind_d = KIND_FILL;
            end else if (ARROW_OUTLINE[arrow_row][arrow_col]) begin
              kind_d = KIND_OUTLINE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      kind_q <= kind_d;
      bg2_q  <= bg1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: color select into the output register.
  // --------------------------------------------------------------------------
  logic [7:0] pixel_d, pixel_q;
  logic       hit_d, hit_q;

  always_comb begin
    case (kind_q)
      KIND_OUTLINE: pixel_d = OUTLINE_COLOR;
      KIND_FILL:    pixel_d = cursor_color_q;
      default:      pixel_d = bg2_q;
    endcase
    hit_d = (kind_q != KIND_MISS);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pixel_q <= pixel_d;
      hit_q   <= hit_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = pixel_q;
  assign m_axis_tuser_o  = hit_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CSO_ASSERT(a_ready_low_only_when_full,
              !s_axis_tready_o |-> (v1_q && v2_q && v3_q),
              "input stalled while the pipeline has room")
  `CSO_ASSERT(a_stage2_holds_on_stall,
              (v2_q && !en3) |=> (v2_q && $stable(kind_q) && $stable(bg2_q)),
              "stage 2 lost its pixel during a stall")
  `CSO_ASSERT(a_stage2_moves_on,
              (v2_q && en3) |=> v3_q,
              "pixel dropped between stage 2 and the output")
  `CSO_ASSERT(a_outside_misses,
              (v1_q && en2 && !in_area_q) |=> (kind_q == KIND_MISS),
              "cursor drawn outside the visible area")
  `CSO_ASSERT_ALWAYS(a_reset_empties,
                     !rst_ni |-> (!v1_q && !v2_q && !v3_q),
                     "pipeline not empty in reset")

endmodule
